FILE: design/u8dec_pkg.sv
`timescale 1ns / 1ps

package u8dec_pkg;

   localparam int ByteWidth  = 8;
   localparam int ValueWidth = 21;
   localparam int CountWidth = 2;
   localparam int DataWidth  = ((ValueWidth + 7) / 8) * 8;

   typedef logic [ByteWidth-1:0]  byte_type;
   typedef logic [ValueWidth-1:0] value_type;
   typedef logic [CountWidth-1:0] count_type;

   localparam count_type LenOne   = 2'd1;
   localparam count_type LenTwo   = 2'd2;
   localparam count_type LenThree = 2'd3;
   localparam count_type LenIdle  = 2'd0;

   typedef struct packed {
      logic      valid;
      value_type value;
      logic      error;
   } result_type;

endpackage

FILE: design/utf8_style_uint_decoder_top.sv
`timescale 1ns / 1ps
// rsp_tvalid is registered: a req byte passes the input register, then the result register
// throughput: one byte per cycle, limited only by rsp_tready backpressure
// a lead byte of a multi-byte sequence gives no result; the last byte gives one
// reset (synchronous, active high) empties both registers and returns the decoder to idle
module utf8_style_uint_decoder_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [u8dec_pkg::ByteWidth-1:0] req_tdata,  // [7:0] byte_in
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [u8dec_pkg::DataWidth-1:0] rsp_tdata,  // [20:0] value, rest zero
   output logic                       rsp_tuser   // [0] error
);
   import u8dec_pkg::*;

   logic       in_valid_ff, in_valid_in;
   byte_type   byte_ff, byte_in;
   count_type  left_ff, left_in;
   value_type  acc_ff, acc_in;
   logic       bad_ff, bad_in;
   logic       rsp_valid_ff, rsp_valid_in;
   value_type  rsp_value_ff, rsp_value_in;
   logic       rsp_err_ff, rsp_err_in;
   logic       advance;
   result_type res;
   count_type  left_dec;
   value_type  acc_dec;
   logic       bad_dec;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      left_dec = left_ff;
      acc_dec  = acc_ff;
      bad_dec  = bad_ff;
      res      = '{valid: 1'b0, value: '0, error: 1'b0};
      if (left_ff == LenIdle) begin
         case (byte_ff) inside
            [8'h00:8'h7F]: begin
               res = '{valid: 1'b1, value: value_type'(byte_ff), error: 1'b0};
            end
            [8'hC0:8'hDF]: begin
               acc_dec  = value_type'(byte_ff[4:0]);
               left_dec = LenOne;
               bad_dec  = 1'b0;
            end
            [8'hE0:8'hEF]: begin
               acc_dec  = value_type'(byte_ff[3:0]);
               left_dec = LenTwo;
               bad_dec  = 1'b0;
            end
            [8'hF0:8'hF7]: begin
               acc_dec  = value_type'(byte_ff[2:0]);
               left_dec = LenThree;
               bad_dec  = 1'b0;
            end
            default: begin
               res = '{valid: 1'b1, value: '0, error: 1'b1};
            end
         endcase
      end else begin
         bad_dec  = bad_ff || (byte_ff[7:6] != 2'b10);
         acc_dec  = {acc_ff[ValueWidth-7:0], byte_ff[5:0]};
         left_dec = left_ff - LenOne;
         if (left_dec == LenIdle) begin
            res     = '{valid: 1'b1, value: bad_dec ? '0 : acc_dec, error: bad_dec};
            acc_dec = '0;
            bad_dec = 1'b0;
         end
      end
   end

   always_comb begin
      in_valid_in  = in_valid_ff;
      byte_in      = byte_ff;
      left_in      = left_ff;
      acc_in       = acc_ff;
      bad_in       = bad_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_err_in   = rsp_err_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         in_valid_in = 1'b0;
         left_in     = left_dec;
         acc_in      = acc_dec;
         bad_in      = bad_dec;
         if (res.valid) begin
            rsp_valid_in = 1'b1;
            rsp_value_in = res.value;
            rsp_err_in   = res.error;
         end
      end
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         byte_in     = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         left_ff      <= LenIdle;
         acc_ff       <= '0;
         bad_ff       <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         left_ff      <= left_in;
         acc_ff       <= acc_in;
         bad_ff       <= bad_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      rsp_value_ff <= rsp_value_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DataWidth'(rsp_value_ff);
   assign rsp_tuser  = rsp_err_ff;

   a_err_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> (rsp_value_ff == '0))
      else $error("error result with nonzero value");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("input stage empty but not ready");

   a_seq_done_idle: assert property (@(posedge clock) disable iff (reset)
      (advance && (left_ff == LenOne)) |=> (left_ff == LenIdle))
      else $error("decoder not idle after last continuation byte");

   a_lead_no_result: assert property (@(posedge clock) disable iff (reset)
      (advance && (left_ff == LenIdle) && (byte_ff[7:6] == 2'b11)
         && (byte_ff[7:3] != 5'b11111)) |=> (left_ff != LenIdle))
      else $error("lead byte did not start a sequence");

   a_mid_no_result: assert property (@(posedge clock) disable iff (reset)
      (advance && ((left_ff == LenTwo) || (left_ff == LenThree))) |-> !res.valid)
      else $error("result inside a sequence");

endmodule
